### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro clocks on a rising edge and disables on an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled channel keeps valid high and its payload unchanged on the next edge
`define AST_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

### hw/rtl/ast_pkg.sv
// shared constants and types of the adc scan telemetry framer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ast_pkg;

	// frame layout
	localparam int CHANNELS     = 8;
	localparam int CH_W         = $clog2(CHANNELS);
	localparam int SAMPLE_W     = 12;
	localparam int DAC_W        = 12;
	localparam int BYTE_W       = 8;
	localparam int FRAME_LEN    = 20;
	localparam int CRC_LEN      = FRAME_LEN - 1;
	localparam int POS_W        = $clog2(FRAME_LEN);
	localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h1B;
	localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;

	// stream widths
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;

	// frame job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// everything the serializer needs for one frame
	typedef struct packed {
		logic [BYTE_W-1:0]            seq;
		logic [CHANNELS*SAMPLE_W-1:0] samples;   // channel 0 in the top bits
		logic [BYTE_W-1:0]            din;
		logic [BYTE_W-1:0]            dout;
		logic [DAC_W-1:0]             dac_a;
		logic [DAC_W-1:0]             dac_b;
	} job_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

endpackage

### hw/rtl/ast_front.sv
// front end: takes sample words, fills the channel slots, posts a frame job on channel 7
// depends on ast_pkg
`timescale 1ns / 1ps

module ast_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// adc_sample[11:0], digital_inputs[19:12], digital_outputs[27:20],
	// dac_first[39:28], dac_second[51:40], zero pad [55:52]
	input  logic [ast_pkg::S_TDATA_W-1:0] s_tdata,
	input  ast_pkg::queue_status_t        q_stat,
	output logic                          push,
	output ast_pkg::job_t                 push_job
);

	logic [ast_pkg::CH_W-1:0]     ch_q;
	logic [ast_pkg::BYTE_W-1:0]   seq_q;
	logic [ast_pkg::SAMPLE_W-1:0] store_q [ast_pkg::CHANNELS-1];
	logic                         is_last;
	logic                         accept;
	logic [ast_pkg::SAMPLE_W-1:0] sample;

	// field split
	assign sample  = s_tdata[11:0];

	// stall only when the closing sample finds the queue full
	assign is_last  = ch_q == ast_pkg::CH_W'(ast_pkg::CHANNELS - 1);
	assign s_tready = !(is_last && q_stat.full);
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && is_last;

	// frame job: stored slots plus the current sample for the last channel
	always_comb begin
		push_job.seq   = seq_q;
		push_job.din   = s_tdata[19:12];
		push_job.dout  = s_tdata[27:20];
		push_job.dac_a = s_tdata[39:28];
		push_job.dac_b = s_tdata[51:40];
		for (int i = 0; i < ast_pkg::CHANNELS - 1; i++) begin
			push_job.samples[(ast_pkg::CHANNELS - 1 - i) * ast_pkg::SAMPLE_W +: ast_pkg::SAMPLE_W] =
				store_q[i];
		end
		push_job.samples[ast_pkg::SAMPLE_W-1:0] = sample;
	end

	// channel counter and sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q  <= '0;
			seq_q <= '0;
		end else if (accept) begin
			ch_q <= is_last ? '0 : ch_q + ast_pkg::CH_W'(1);
			if (is_last) begin
				seq_q <= seq_q + ast_pkg::BYTE_W'(1);
			end
		end
	end

	// sample slots, last channel goes straight into the job
	always_ff @(posedge clk) begin
		if (accept && !is_last) begin
			store_q[ch_q] <= sample;
		end
	end

endmodule

### hw/rtl/ast_queue.sv
// short frame job queue decoupling the front end from the serializer
// depends on ast_pkg
`timescale 1ns / 1ps

module ast_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ast_pkg::job_t          push_job,
	input  logic                   pop,
	output ast_pkg::queue_status_t q_stat,
	output ast_pkg::job_t          head_job
);

	ast_pkg::job_t               entries_q [ast_pkg::QUEUE_DEPTH];
	logic [ast_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ast_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ast_pkg::QCNT_W-1:0]  count_q;

	assign q_stat.full  = count_q == ast_pkg::QCNT_W'(ast_pkg::QUEUE_DEPTH);
	assign q_stat.valid = count_q != '0;
	assign head_job     = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ast_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ast_pkg::QPTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + ast_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ast_pkg::QCNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hw/rtl/ast_back.sv
// serializer: walks one frame job byte by byte and runs the crc-8 alongside
// depends on ast_pkg
`timescale 1ns / 1ps

module ast_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ast_pkg::queue_status_t        q_stat,
	input  ast_pkg::job_t                 head_job,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_byte[7:0], byte_position[12:8], zero pad [15:13]
	output logic [ast_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int VEC_W = ast_pkg::CRC_LEN * ast_pkg::BYTE_W;

	logic                        busy_q;
	ast_pkg::job_t               job_q;
	logic [ast_pkg::POS_W-1:0]   pos_q;
	logic [ast_pkg::BYTE_W-1:0]  crc_q;
	logic                        out_valid_q;
	logic [ast_pkg::BYTE_W-1:0]  out_byte_q;
	logic [ast_pkg::POS_W-1:0]   out_pos_q;
	logic                        out_last_q;
	logic [VEC_W-1:0]            frame_vec;
	logic [ast_pkg::BYTE_W-1:0]  frame_bytes [ast_pkg::FRAME_LEN];
	logic [ast_pkg::BYTE_W-1:0]  cur_byte;
	logic                        is_last_pos;
	logic                        emit;

	// one crc-8 step over a byte, msb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			v = v[7] ? ((v << 1) ^ ast_pkg::CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	// frame bytes in order, crc byte last
	assign frame_vec = {ast_pkg::FRAME_HEADER, job_q.seq, job_q.samples,
	                    job_q.din, job_q.dout, job_q.dac_a, job_q.dac_b};
	always_comb begin
		for (int p = 0; p < ast_pkg::CRC_LEN; p++) begin
			frame_bytes[p] = frame_vec[(ast_pkg::CRC_LEN - 1 - p) * ast_pkg::BYTE_W +: ast_pkg::BYTE_W];
		end
		frame_bytes[ast_pkg::CRC_LEN] = crc_q;
	end
	assign cur_byte = frame_bytes[pos_q];

	// advance when the output register is free or being drained
	assign is_last_pos = pos_q == ast_pkg::POS_W'(ast_pkg::FRAME_LEN - 1);
	assign emit        = busy_q && (!out_valid_q || m_tready);
	assign pop         = q_stat.valid && (!busy_q || (emit && is_last_pos));

	// frame walk and crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			crc_q  <= '0;
		end else begin
			priority if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
				crc_q  <= '0;
			end else if (emit && is_last_pos) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + ast_pkg::POS_W'(1);
				crc_q <= crc8_update(crc_q, cur_byte);
			end else begin
				busy_q <= busy_q;
			end
		end
	end

	// job capture
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_pos_q  <= pos_q;
			out_last_q <= is_last_pos;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_pos_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

### hw/rtl/adc_scan_telemetry_framer.sv
// top level of the adc scan telemetry framer
// depends on ast_pkg, ast_front, ast_queue and ast_back
`timescale 1ns / 1ps

// Each input word is one sample tick: the 12-bit sample goes into the slot of the internal
// channel counter (0..7, restarting at 0 after reset). The tick that carries channel 7 posts a
// frame to a two-entry queue and, as soon as the serializer is free, the block sends 20 output
// words: header 0x1B, sequence number, the eight samples packed msb first in 12 bytes, the
// digital input and output bytes, both dac values in 3 bytes and a crc-8 (poly 0x07, init 0)
// over bytes 0..18; tlast marks the crc byte. The serializer produces one byte per clock
// when the output is not stalled, with the next queued frame following directly. Input words
// are taken every cycle; only a channel 7 word waits while both queue entries hold frames not
// yet started.

module adc_scan_telemetry_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// adc_sample[11:0], digital_inputs[19:12], digital_outputs[27:20],
	// dac_first[39:28], dac_second[51:40], zero pad [55:52]
	input  logic [ast_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_byte[7:0], byte_position[12:8], zero pad [15:13]
	output logic [ast_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	ast_pkg::queue_status_t q_stat;
	ast_pkg::job_t          push_job;
	ast_pkg::job_t          head_job;
	logic                   push;
	logic                   pop;

	// sample capture and job build
	ast_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// frame job queue
	ast_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_stat   (q_stat),
		.head_job (head_job)
	);

	// byte serializer
	ast_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_job (head_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/ast_checker.sv
// port-level checks of the adc scan telemetry framer, bound to the top level
// depends on ast_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ast_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ast_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	logic [ast_pkg::POS_W-1:0] exp_pos_q;
	logic [ast_pkg::CH_W-1:0]  in_ch_q;
	logic [ast_pkg::POS_W-1:0] out_pos;
	logic                      is_crc_pos;
	logic                      in_closing;

	assign out_pos    = m_tdata[12:8];
	assign is_crc_pos = out_pos == ast_pkg::POS_W'(ast_pkg::FRAME_LEN - 1);
	assign in_closing = in_ch_q == ast_pkg::CH_W'(ast_pkg::CHANNELS - 1);

	// expected position of the next output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_pos_q <= m_tlast ? '0 : exp_pos_q + ast_pkg::POS_W'(1);
		end
	end

	// channel of the next input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q <= '0;
		end else if (s_tvalid && s_tready) begin
			in_ch_q <= in_ch_q + ast_pkg::CH_W'(1);
		end
	end

	// bytes of a frame come in order with no gap or repeat
	`AST_ASSERT(a_pos_order, clk, arst_n, m_tvalid |-> (out_pos == exp_pos_q), "byte position out of order")

	// tlast sits on the crc byte and nowhere else
	`AST_ASSERT(a_last_pos, clk, arst_n, m_tvalid |-> (m_tlast == is_crc_pos), "tlast not on crc byte")

	// every frame opens with the header byte
	`AST_ASSERT(a_header, clk, arst_n, (m_tvalid && out_pos == '0) |-> (m_tdata[7:0] == ast_pkg::FRAME_HEADER), "frame header wrong")

	// only the closing channel word can be held off
	`AST_ASSERT(a_in_ready, clk, arst_n, !in_closing |-> s_tready, "input stalled on a non-closing channel")

	// a stalled output word holds
	`AST_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, {m_tdata, m_tlast}, "output word changed while stalled")

endmodule

bind adc_scan_telemetry_framer ast_checker u_ast_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
